// ===== hw/rtl/field_unescape_decoder_macros.svh =====
// Assertion macros for the escape decoder.
// No dependencies; included by the top level only.
`ifndef FIELD_UNESCAPE_DECODER_MACROS_SVH
`define FIELD_UNESCAPE_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FUD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FUD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fud_pkg.sv =====
// Shared types, character codes and hex digit helper for the escape decoder.
// No dependencies.
package fud_pkg;

    localparam logic [7:0] BS_CHAR = 8'h5C;
    localparam logic [7:0] X_CHAR  = 8'h78;
    localparam int         MAX_OUT = 4;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BS     = 2'd1,
        PH_BS_X   = 2'd2,
        PH_BS_X_D = 2'd3
    } phase_t;

    // One accepted byte's worth of output bytes plus state update.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    last;
        phase_t                  phase_next;
        logic                    hold_load;
    } grp_t;

    // Bit 4 set means not a hex digit.
    function automatic logic [4:0] digit_value(input logic [7:0] ch);
        logic [4:0] v;
        v = 5'h10;
        if (ch >= 8'h30 && ch <= 8'h39) v = {1'b0, 4'(ch - 8'h30)};
        else if (ch >= 8'h61 && ch <= 8'h66) v = {1'b0, 4'(ch - 8'h57)};
        else if (ch >= 8'h41 && ch <= 8'h46) v = {1'b0, 4'(ch - 8'h37)};
        return v;
    endfunction

endpackage

// ===== hw/rtl/fud_decode.sv =====
// Combinational escape decode: phase, held digit and one input byte in,
// a group of up to four output bytes and the next phase out. Uses fud_pkg.
module fud_decode
    import fud_pkg::*;
(
    input  phase_t     phase,
    input  logic [7:0] held_digit,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output grp_t       grp
);

    logic                    absorb;
    logic                    is_hex;
    logic [4:0]              hi_v;
    logic [4:0]              lo_v;
    logic [1:0]              npre;
    logic                    plain;
    logic [7:0]              pre [3];
    phase_t                  phase_out;
    logic                    hold_out;
    logic [MAX_OUT-1:0][7:0] bytes_out;
    logic [2:0]              count_out;

    assign absorb = (in_byte == BS_CHAR) && !in_last;
    assign lo_v   = digit_value(in_byte);
    assign hi_v   = digit_value(held_digit);
    assign is_hex = !lo_v[4];
    assign pre[0] = BS_CHAR;
    assign pre[1] = X_CHAR;
    assign pre[2] = held_digit;

    assign grp = '{bytes: bytes_out, count: count_out, last: in_last,
                   phase_next: phase_out, hold_load: hold_out};

    // next state
    always_comb begin
        phase_out = absorb ? PH_BS : PH_IDLE;
        hold_out  = 1'b0;
        unique case (phase)
            PH_IDLE: ;
            PH_BS: begin
                if (in_byte == BS_CHAR) phase_out = PH_IDLE;
                else if (in_byte == X_CHAR && !in_last) phase_out = PH_BS_X;
            end
            PH_BS_X: begin
                if (is_hex && !in_last) begin
                    phase_out = PH_BS_X_D;
                    hold_out  = 1'b1;
                end
            end
            PH_BS_X_D: begin
                if (is_hex && !hi_v[4]) phase_out = PH_IDLE;
            end
            default: ;
        endcase
    end

    // output group
    always_comb begin
        bytes_out = '0;
        count_out = 3'd0;
        npre      = 2'd0;
        plain     = 1'b1;
        unique case (phase)
            PH_IDLE: ;
            PH_BS: begin
                if (in_byte == BS_CHAR || (in_byte == X_CHAR && !in_last)) plain = 1'b0;
                else npre = 2'd1;
            end
            PH_BS_X: begin
                if (is_hex && !in_last) plain = 1'b0;
                else npre = 2'd2;
            end
            PH_BS_X_D: begin
                if (is_hex && !hi_v[4]) plain = 1'b0;
                else npre = 2'd3;
            end
            default: ;
        endcase

        if (plain) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < npre) bytes_out[i] = pre[i];
            end
            bytes_out[npre] = in_byte;
            count_out       = {1'b0, npre} + (absorb ? 3'd0 : 3'd1);
        end else if (phase == PH_BS && in_byte == BS_CHAR) begin
            bytes_out[0] = BS_CHAR;
            count_out    = 3'd1;
        end else if (phase == PH_BS_X_D) begin
            bytes_out[0] = {hi_v[3:0], lo_v[3:0]};
            count_out    = 3'd1;
        end
    end

endmodule

// ===== hw/rtl/field_unescape_decoder.sv =====
// Backslash / hex escape decoder, one escaped byte in, zero to four bytes out.
// The first output byte appears on m_tdata in the cycle after its input transfer.
// Throughput: one byte per cycle while each input yields at most one byte and m_tready
// stays high; a failed escape yields up to four bytes, drained from the output buffer
// one per cycle while m_tready is high, and input is held off until the buffer is nearly empty.
// Reset (aresetn low, synchronous): buffer empty, no escape pending.
`include "field_unescape_decoder_macros.svh"

module field_unescape_decoder
    import fud_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    phase_t                  phase_reg, phase_next;
    logic [7:0]              held_reg, held_next;
    logic [MAX_OUT-1:0][7:0] buf_reg, buf_next;
    logic [2:0]              cnt_reg, cnt_next;
    logic                    last_reg, last_next;
    grp_t                    grp;
    logic                    s_xfer;
    logic                    m_xfer;

    fud_decode u_decode (
        .phase      (phase_reg),
        .held_digit (held_reg),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .grp        (grp)
    );

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = last_reg && (cnt_reg == 3'd1);
    assign m_xfer   = m_tvalid && m_tready;
    // buffer is free once its final byte leaves in this cycle
    assign s_tready = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        if (s_xfer) begin
            phase_next = grp.phase_next;
            if (grp.hold_load) held_next = s_tdata;
            buf_next  = grp.bytes;
            cnt_next  = grp.count;
            last_next = grp.last;
        end else if (m_xfer) begin
            buf_next = {8'h00, buf_reg[MAX_OUT-1:1]};
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
            cnt_reg   <= 3'd0;
            last_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    `FUD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= 3'd4, "output buffer count out of range")
    `FUD_ASSERT_IMP(a_tlast_single, m_tlast, cnt_reg == 3'd1, "tlast not on final byte")
    `FUD_ASSERT_NXT(a_end_idle, s_xfer && s_tlast, phase_reg == PH_IDLE, "escape pending after end")
    `FUD_ASSERT_NXT(a_hold_quiet, s_xfer && grp.phase_next != PH_IDLE && phase_reg != PH_IDLE && grp.count == 3'd0, cnt_reg == 3'd0, "held byte produced output")

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for field_unescape_decoder: directed escape texts, then random texts.
// Needs fud_pkg for the phase enum and character codes; the DUT drives results on m_.
module tb
    import fud_pkg::*;
();

    localparam int QUIET_LIMIT = 1000;   // cycles with no transfer before giving up
    localparam int RANDOM_ITEMS = 150;

    typedef logic [7:0] text_t[$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    // Tracks the escape state of the input stream and the decoded bytes still owed.
    class unescape_scoreboard;
        phase_t     phase;
        logic [7:0] first_digit;
        dec_byte_t  owed[$];
        int         mismatches;
        int         checked;
        int         hex_decoded;
        int         escapes_failed;

        function new();
            phase = PH_IDLE;
            first_digit = 8'h00;
            mismatches = 0;
            checked = 0;
            hex_decoded = 0;
            escapes_failed = 0;
        endfunction

        function int hex_nibble(logic [7:0] ch);
            if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
            if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
            if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
            return -1;
        endfunction

        function void owe(logic [7:0] b, logic l);
            dec_byte_t d;
            d.data = b;
            d.last = l;
            owed = {owed, d};
        endfunction

        // Byte seen with no escape pending; a backslash opens one unless the text ends.
        function void plain_byte(logic [7:0] b, logic l);
            if (b == BS_CHAR && !l) begin
                phase = PH_BS;
            end else begin
                owe(b, l);
                phase = PH_IDLE;
            end
        endfunction

        function void note_input(logic [7:0] b, logic l);
            int hi;
            int lo;
            case (phase)
                PH_IDLE: begin
                    plain_byte(b, l);
                end
                PH_BS: begin
                    if (b == BS_CHAR) begin
                        owe(BS_CHAR, l);
                        phase = PH_IDLE;
                    end else if (b == X_CHAR && !l) begin
                        phase = PH_BS_X;
                    end else begin
                        escapes_failed++;
                        owe(BS_CHAR, 1'b0);
                        plain_byte(b, l);
                    end
                end
                PH_BS_X: begin
                    if (hex_nibble(b) >= 0 && !l) begin
                        first_digit = b;
                        phase = PH_BS_X_D;
                    end else begin
                        escapes_failed++;
                        owe(BS_CHAR, 1'b0);
                        owe(X_CHAR, 1'b0);
                        plain_byte(b, l);
                    end
                end
                default: begin
                    hi = hex_nibble(first_digit);
                    lo = hex_nibble(b);
                    if (hi >= 0 && lo >= 0) begin
                        hex_decoded++;
                        owe(8'((hi << 4) | lo), l);
                        phase = PH_IDLE;
                    end else begin
                        // held bytes go out as plain text, current byte replayed from idle
                        escapes_failed++;
                        owe(BS_CHAR, 1'b0);
                        owe(X_CHAR, 1'b0);
                        owe(first_digit, 1'b0);
                        plain_byte(b, l);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [7:0] b, logic l);
            dec_byte_t exp_byte;
            checked++;
            if (owed.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output transfer data=%h last=%b", $time, b, l);
                return;
            end
            exp_byte = owed.pop_front();
            if (b !== exp_byte.data) begin
                mismatches++;
                $display("%0t: out_byte mismatch expected=%h actual=%h",
                         $time, exp_byte.data, b);
            end
            if (l !== exp_byte.last) begin
                mismatches++;
                $display("%0t: out_last mismatch expected=%b actual=%b",
                         $time, exp_byte.last, l);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    unescape_scoreboard sb = new();

    bit calm = 1'b0;        // no idling on either side while set
    int items_sent = 0;
    int texts_sent = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    field_unescape_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] hex_char();
        string digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // Well-formed escapes with random content, mixed with broken escapes and noise.
    function automatic text_t random_text();
        text_t t;
        int tokens;
        int kind;
        tokens = $urandom_range(1, 8);
        for (int i = 0; i < tokens; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                t = {t, BS_CHAR, X_CHAR, hex_char(), hex_char()};
            end else if (kind < 48) begin
                t = {t, BS_CHAR, BS_CHAR};
            end else if (kind < 68) begin
                t = {t, BS_CHAR};
                if ($urandom_range(0, 2) > 0) begin
                    t = {t, X_CHAR};
                    if ($urandom_range(0, 1) == 1) t = {t, hex_char()};
                end
                t = {t, 8'($urandom_range(0, 255))};
            end else begin
                t = {t, 8'($urandom_range(0, 255))};
            end
        end
        return t;
    endfunction

    // Called at a rising edge; returns at the edge where the byte is accepted.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, l);
        items_sent++;
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i]) send_byte(t[i], i == t.size() - 1);
        texts_sent++;
    endtask

    // Stops offering input, then waits until every owed byte has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.owed.size() != 0) @(posedge aclk);
    endtask

    // Result side: check each transfer, then choose the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, sb.owed.size());
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        text_t t;
        int random_start;
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // escaped backslash, then a zero byte ending the text
        t = {BS_CHAR, BS_CHAR, 8'h00};
        send_text(t);
        // lower and upper case hex digits, all-ones byte last
        t = {BS_CHAR, X_CHAR, "a", "F", 8'hFF};
        send_text(t);
        // escape that fails right after the backslash
        t = {BS_CHAR, "q"};
        send_text(t);
        // failed hex escape whose replayed backslash opens another, which fails on 'G'
        t = {BS_CHAR, X_CHAR, "4", BS_CHAR, X_CHAR, "G"};
        send_text(t);
        // lone trailing backslash
        t = {BS_CHAR};
        send_text(t);
        // text ends right after the 'x'
        t = {BS_CHAR, X_CHAR};
        send_text(t);
        // full four-byte burst, ending the text
        t = {BS_CHAR, X_CHAR, "5", "!"};
        send_text(t);

        // hold off until the decoder has emptied
        drain_results();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            send_text(random_text());
            if ($urandom_range(0, 7) == 0) drain_results();
        end
        calm = 1'b0;

        drain_results();
        repeat (20) @(posedge aclk);
        if (sb.owed.size() != 0) begin
            sb.mismatches++;
            $display("%0t: %0d expected bytes never arrived", $time, sb.owed.size());
        end

        $display("Sent %0d bytes in %0d texts; checked %0d output bytes.",
                 items_sent, texts_sent, sb.checked);
        $display("Hex escapes decoded: %0d, escapes broken and replayed: %0d.",
                 sb.hex_decoded, sb.escapes_failed);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fud_pkg.sv
hw/rtl/fud_decode.sv
hw/rtl/field_unescape_decoder.sv
bench/tb.sv
